// ===== sv/tght_pkg.sv =====
package tght_pkg;

  localparam int TEMP_W      = 12;
  localparam int CFG_T_W     = 8;
  localparam int EPS_W       = 20;
  localparam int DECAY_W     = 16;
  localparam int ROM_W       = 32;
  localparam int ROM_DEPTH   = 256;
  localparam int WEIGHT_W    = 9;
  localparam int OFF_W       = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int APB_AW      = 4;

  // register indexes on the configuration port
  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_CLAMP = 2'd1;
  localparam logic [1:0] REG_EPS   = 2'd2;
  localparam logic [1:0] REG_DECAY = 2'd3;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DECAY = 1'b1;

  typedef logic [ROM_W-1:0] heat_rom_t [ROM_DEPTH];

  localparam logic [63:0] QUARTER_POW [4] = '{
    64'd1048576, 64'd1097476, 64'd1148657, 64'd1202225
  };

  // 1.2^(t/4) in Q8, t in quarter degrees; unsaturated
  function automatic heat_rom_t build_heat_rom();
    heat_rom_t   rom;
    logic [63:0] p;
    logic [63:0] h;
    for (int t = 0; t < ROM_DEPTH; t++) begin
      p = 64'd1 << 24;
      for (int i = 0; i < (t >> 2); i++) begin
        p = (p * 64'd6 + 64'd2) / 64'd5;
      end
      h = (p * QUARTER_POW[t % 4] + (64'd1 << 35)) >> 36;
      rom[t] = h[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam heat_rom_t HEAT_ROM = build_heat_rom();

  // 420 / (1 + d)
  function automatic logic [WEIGHT_W-1:0] weight_of(logic [2:0] d);
    logic [WEIGHT_W-1:0] w;
    unique case (d)
      3'd0:    w = 9'd420;
      3'd1:    w = 9'd210;
      3'd2:    w = 9'd140;
      3'd3:    w = 9'd105;
      3'd4:    w = 9'd84;
      3'd5:    w = 9'd70;
      3'd6:    w = 9'd60;
      default: w = 9'd52;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/tght_front.sv =====
module tght_front #(
  parameter int HEAT_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic signed [tght_pkg::TEMP_W-1:0] temp_i,
  input  logic [tght_pkg::CFG_T_W-1:0]      low_i,
  input  logic [tght_pkg::CFG_T_W-1:0]      clamp_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_op_o,
  output logic [HEAT_WIDTH-1:0]             out_heat_o
);

  localparam logic [tght_pkg::ROM_W:0] HEAT_MAX =
    (33'd1 << HEAT_WIDTH) - 33'd1;

  logic                  valid_q;
  logic                  op_q;
  logic [HEAT_WIDTH-1:0] heat_q;

  logic signed [tght_pkg::TEMP_W:0] temp_ext;
  logic signed [tght_pkg::TEMP_W:0] low_ext;
  logic signed [tght_pkg::TEMP_W:0] clamp_ext;
  logic [tght_pkg::CFG_T_W-1:0]     t;
  logic [tght_pkg::ROM_W-1:0]       rom_val;
  logic [HEAT_WIDTH-1:0]            heat_sat;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_op_o    = op_q;
  assign out_heat_o  = heat_q;

  always_comb begin
    temp_ext  = {temp_i[tght_pkg::TEMP_W-1], temp_i};
    low_ext   = $signed({5'd0, low_i});
    clamp_ext = $signed({5'd0, clamp_i});
    // zero first, then clamp
    priority if (temp_ext < low_ext) begin
      t = '0;
    end else if (temp_ext > clamp_ext) begin
      t = clamp_i;
    end else begin
      t = temp_i[tght_pkg::CFG_T_W-1:0];
    end
    rom_val = tght_pkg::HEAT_ROM[t];
    if ({1'b0, rom_val} > HEAT_MAX) begin
      heat_sat = HEAT_MAX[HEAT_WIDTH-1:0];
    end else begin
      heat_sat = rom_val[HEAT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_i;
      heat_q <= heat_sat;
    end
  end

endmodule

// ===== sv/tght_queue.sv =====
module tght_queue #(
  parameter int WIDTH = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int DEPTH = tght_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != DEPTH[PW:0]);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_data_i;
  end

endmodule

// ===== sv/tght_back.sv =====
module tght_back #(
  parameter int GRID_SIDE     = 8,
  parameter int WINDOW_RADIUS = 1,
  parameter int HEAT_WIDTH    = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               item_valid_i,
  output logic                               item_ready_o,
  input  logic                               item_op_i,
  input  logic [HEAT_WIDTH-1:0]              item_heat_i,
  input  logic [tght_pkg::EPS_W-1:0]         eps_i,
  input  logic [tght_pkg::DECAY_W-1:0]       decay_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic [$clog2(GRID_SIDE)-1:0]       res_x_o,
  output logic [$clog2(GRID_SIDE)-1:0]       res_y_o,
  output logic [HEAT_WIDTH-1:0]              res_value_o,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] res_index_o,
  output logic                               res_kept_o
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int IW    = $clog2(CELLS);
  localparam int SW    = CW + 2;
  localparam int WW    = tght_pkg::WEIGHT_W;
  localparam int NUM_W = HEAT_WIDTH + 15;
  localparam int N_W   = HEAT_WIDTH + 17;
  localparam int DEN_W = 15;
  localparam int D_W   = 16;
  localparam int DCW   = $clog2(HEAT_WIDTH);
  localparam int CMP_W = ((HEAT_WIDTH > tght_pkg::EPS_W) ? HEAT_WIDTH : tght_pkg::EPS_W) + 1;
  localparam int OW    = tght_pkg::OFF_W;
  localparam logic signed [OW-1:0] RAD = OW'(WINDOW_RADIUS);
  localparam logic [CW-1:0] LAST_RC = CW'(GRID_SIDE - 1);
  localparam logic [IW-1:0] LAST_CELL = IW'(CELLS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_ACC_END, ST_DIV_LOAD, ST_DIV, ST_NEXT, ST_DONE
  } state_e;

  state_e state_q;

  logic [HEAT_WIDTH-1:0] mem [CELLS];

  logic [IW-1:0]           wr_cnt_q;
  logic [CW-1:0]           row_q, col_q;
  logic signed [OW-1:0]    di_q, dj_q;
  logic                    rd_valid_q;
  logic [WW-1:0]           w_q;
  logic [HEAT_WIDTH-1:0]   rd_data_q;
  logic [NUM_W-1:0]        num_q;
  logic [DEN_W-1:0]        den_q;
  logic [D_W-1:0]          rem_q;
  logic [HEAT_WIDTH-1:0]   lo_q;
  logic [DCW-1:0]          div_cnt_q;
  logic [HEAT_WIDTH-1:0]   bval_q;
  logic [CW-1:0]           bx_q, by_q;
  logic [CW-1:0]           prev_x_q, prev_y_q;
  logic [HEAT_WIDTH-1:0]   prev_value_q;
  logic                    prev_valid_q;
  logic                    res_valid_q;
  logic [CW-1:0]           res_x_q, res_y_q;
  logic [HEAT_WIDTH-1:0]   res_value_q;
  logic [IW-1:0]           res_index_q;
  logic                    res_kept_q;

  logic signed [SW-1:0]    ti, tj;
  logic                    tap_ok;
  logic [IW-1:0]           tap_addr;
  logic [2:0]              tap_dist;
  logic                    tap_last;
  logic [N_W-1:0]          n_full;
  logic [D_W-1:0]          d_val;
  logic [D_W:0]            div_sh;
  logic                    div_ge;
  logic [HEAT_WIDTH+tght_pkg::DECAY_W-1:0] decay_prod;
  logic                    keep;
  logic [CMP_W-1:0]        keep_lim;
  logic [HEAT_WIDTH+WW-1:0] term;

  function automatic logic [1:0] mag(logic signed [OW-1:0] v);
    logic signed [OW-1:0] a;
    a = (v < 0) ? -v : v;
    return a[1:0];
  endfunction

  always_comb begin
    ti       = $signed({2'b00, row_q}) + SW'(di_q);
    tj       = $signed({2'b00, col_q}) + SW'(dj_q);
    tap_ok   = (ti >= 0) && (ti < SW'(GRID_SIDE)) && (tj >= 0) && (tj < SW'(GRID_SIDE));
    tap_addr = IW'(ti[CW-1:0] * GRID_SIDE + tj[CW-1:0]);
    tap_dist = {1'b0, mag(di_q)} + {1'b0, mag(dj_q)};
    tap_last = (di_q == RAD) && (dj_q == RAD);
    term     = rd_data_q * w_q;
    n_full   = {1'b0, num_q, 1'b0} + N_W'(den_q);
    d_val    = {den_q, 1'b0};
    div_sh   = {rem_q, lo_q[HEAT_WIDTH-1]};
    div_ge   = div_sh >= {1'b0, d_val};
    decay_prod = prev_value_q * decay_i + (HEAT_WIDTH+tght_pkg::DECAY_W)'(32'h8000);
    keep_lim = CMP_W'(prev_value_q) + CMP_W'(eps_i);
    keep     = prev_valid_q && (CMP_W'(bval_q) < keep_lim);
  end

  assign item_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = res_valid_q;
  assign res_x_o      = res_x_q;
  assign res_y_o      = res_y_q;
  assign res_value_o  = res_value_q;
  assign res_index_o  = res_index_q;
  assign res_kept_o   = res_kept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wr_cnt_q     <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_value_q <= '0;
      prev_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i && state_q != ST_DONE) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            if (item_op_i == tght_pkg::OP_DECAY) begin
              prev_value_q <= decay_prod[tght_pkg::DECAY_W +: HEAT_WIDTH];
            end else if (wr_cnt_q == LAST_CELL) begin
              wr_cnt_q   <= '0;
              row_q      <= '0;
              col_q      <= '0;
              di_q       <= -RAD;
              dj_q       <= -RAD;
              num_q      <= '0;
              den_q      <= '0;
              rd_valid_q <= 1'b0;
              bval_q     <= '0;
              bx_q       <= '0;
              by_q       <= '0;
              state_q    <= ST_ACC;
            end else begin
              wr_cnt_q <= wr_cnt_q + 1'b1;
            end
          end
        end
        ST_ACC: begin
          rd_valid_q <= tap_ok;
          w_q        <= tght_pkg::weight_of(tap_dist);
          if (rd_valid_q) begin
            num_q <= num_q + NUM_W'(term);
            den_q <= den_q + DEN_W'(w_q);
          end
          if (tap_last) begin
            state_q <= ST_ACC_END;
          end else if (dj_q == RAD) begin
            dj_q <= -RAD;
            di_q <= di_q + 1'b1;
          end else begin
            dj_q <= dj_q + 1'b1;
          end
        end
        ST_ACC_END: begin
          rd_valid_q <= 1'b0;
          if (rd_valid_q) begin
            num_q <= num_q + NUM_W'(term);
            den_q <= den_q + DEN_W'(w_q);
          end
          state_q <= ST_DIV_LOAD;
        end
        ST_DIV_LOAD: begin
          rem_q     <= n_full[HEAT_WIDTH +: D_W];
          lo_q      <= n_full[HEAT_WIDTH-1:0];
          div_cnt_q <= DCW'(HEAT_WIDTH - 1);
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= div_ge ? D_W'(div_sh - {1'b0, d_val}) : div_sh[D_W-1:0];
          lo_q  <= {lo_q[HEAT_WIDTH-2:0], div_ge};
          if (div_cnt_q == '0) begin
            state_q <= ST_NEXT;
          end else begin
            div_cnt_q <= div_cnt_q - 1'b1;
          end
        end
        ST_NEXT: begin
          // first strict maximum in scan order wins
          if (lo_q > bval_q) begin
            bval_q <= lo_q;
            bx_q   <= col_q;
            by_q   <= row_q;
          end
          num_q <= '0;
          den_q <= '0;
          di_q  <= -RAD;
          dj_q  <= -RAD;
          if (col_q == LAST_RC) begin
            col_q <= '0;
            if (row_q == LAST_RC) begin
              state_q <= ST_DONE;
            end else begin
              row_q   <= row_q + 1'b1;
              state_q <= ST_ACC;
            end
          end else begin
            col_q   <= col_q + 1'b1;
            state_q <= ST_ACC;
          end
        end
        ST_DONE: begin
          if (!res_valid_q || res_ready_i) begin
            res_valid_q  <= 1'b1;
            res_kept_q   <= keep;
            prev_valid_q <= 1'b1;
            if (keep) begin
              res_x_q     <= prev_x_q;
              res_y_q     <= prev_y_q;
              res_value_q <= prev_value_q;
              res_index_q <= IW'(prev_y_q * GRID_SIDE + prev_x_q);
            end else begin
              res_x_q      <= bx_q;
              res_y_q      <= by_q;
              res_value_q  <= bval_q;
              res_index_q  <= IW'(by_q * GRID_SIDE + bx_q);
              prev_x_q     <= bx_q;
              prev_y_q     <= by_q;
              prev_value_q <= bval_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i && item_op_i == tght_pkg::OP_PIXEL) begin
      mem[wr_cnt_q] <= item_heat_i;
    end
    if (state_q == ST_ACC && tap_ok) begin
      rd_data_q <= mem[tap_addr];
    end
  end

endmodule

// ===== sv/thermal_grid_hotspot_tracker.sv =====
// Pixel items: a registered front stage, then a four-entry queue; the back
// stores one pixel per cycle while idle, so pixels stream at one per cycle
// until the last pixel of a frame. Then the back smooths every cell in turn
// (window reads, then a one-bit-per-cycle divider) and places the result
// item once the output is free. Decay items scale the previous hotspot value
// without taking the back out of its idle state.
// Reset (rst_ni low, asynchronous) clears counters, previous hotspot and all
// handshakes, and loads the register defaults; the frame store is not cleared.
module thermal_grid_hotspot_tracker #(
  parameter int GRID_SIDE     = 8,
  parameter int WINDOW_RADIUS = 1,
  parameter int HEAT_WIDTH    = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // pixel_temp
  input  logic                              s_axis_tuser,  // operation
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // spot_x, spot_y, spot_value, spot_index, zero fill
  output logic [((4*$clog2(GRID_SIDE)+HEAT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                              m_axis_tuser,  // kept_previous
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tght_pkg::APB_AW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CW   = $clog2(GRID_SIDE);
  localparam int IW   = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int TD_W = ((4 * CW + HEAT_WIDTH + 7) / 8) * 8;

  logic [tght_pkg::CFG_T_W-1:0] low_q, clamp_q;
  logic [tght_pkg::EPS_W-1:0]   eps_q;
  logic [tght_pkg::DECAY_W-1:0] decay_q;
  logic [1:0]                   reg_idx;
  logic                         wr_en;

  logic                  f_valid, f_ready, f_op;
  logic [HEAT_WIDTH-1:0] f_heat;
  logic                  q_valid, q_ready;
  logic [HEAT_WIDTH:0]   q_data;

  logic [CW-1:0]         r_x, r_y;
  logic [HEAT_WIDTH-1:0] r_value;
  logic [IW-1:0]         r_index;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      tght_pkg::REG_LOW:   prdata = {24'd0, low_q};
      tght_pkg::REG_CLAMP: prdata = {24'd0, clamp_q};
      tght_pkg::REG_EPS:   prdata = {12'd0, eps_q};
      tght_pkg::REG_DECAY: prdata = {16'd0, decay_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= 8'd108;
      clamp_q <= 8'd132;
      eps_q   <= 20'd256;
      decay_q <= 16'd58982;
    end else if (wr_en) begin
      unique case (reg_idx)
        tght_pkg::REG_LOW:   low_q   <= pwdata[7:0];
        tght_pkg::REG_CLAMP: clamp_q <= pwdata[7:0];
        tght_pkg::REG_EPS:   eps_q   <= pwdata[19:0];
        tght_pkg::REG_DECAY: decay_q <= pwdata[15:0];
        default:             low_q   <= low_q;
      endcase
    end
  end

  tght_front #(
    .HEAT_WIDTH(HEAT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .temp_i     ($signed(s_axis_tdata[tght_pkg::TEMP_W-1:0])),
    .low_i      (low_q),
    .clamp_i    (clamp_q),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .out_op_o   (f_op),
    .out_heat_o (f_heat)
  );

  tght_queue #(
    .WIDTH(HEAT_WIDTH + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_op, f_heat}),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  tght_back #(
    .GRID_SIDE    (GRID_SIDE),
    .WINDOW_RADIUS(WINDOW_RADIUS),
    .HEAT_WIDTH   (HEAT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .item_op_i   (q_data[HEAT_WIDTH]),
    .item_heat_i (q_data[HEAT_WIDTH-1:0]),
    .eps_i       (eps_q),
    .decay_i     (decay_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_x_o     (r_x),
    .res_y_o     (r_y),
    .res_value_o (r_value),
    .res_index_o (r_index),
    .res_kept_o  (m_axis_tuser)
  );

  assign m_axis_tdata = TD_W'({r_index, r_value, r_y, r_x});

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int SIDE   = 8;
  localparam int NCELLS = SIDE * SIDE;
  localparam int HMAX   = (1 << 20) - 1;

  typedef struct packed {
    logic [2:0]  x;
    logic [2:0]  y;
    logic [19:0] value;
    logic [5:0]  index;
    logic        kept;
  } spot_t;

  class hotspot_scoreboard;
    logic [7:0]    low_thr;
    logic [7:0]    clamp;
    logic [19:0]   epsilon;
    logic [15:0]   decay;
    logic [63:0]   heat [NCELLS];
    int            fill;
    logic [2:0]    last_x;
    logic [2:0]    last_y;
    logic [63:0]   last_val;
    bit            last_ok;
    spot_t         spots_due [$];
    int            mismatches;
    int            seen;

    function void reset_state();
      low_thr = 8'd108; clamp = 8'd132; epsilon = 20'd256; decay = 16'd58982;
      fill = 0; last_x = '0; last_y = '0; last_val = '0; last_ok = 1'b0;
      mismatches = 0; seen = 0;
      spots_due.delete();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        tght_pkg::REG_LOW:   low_thr = val[7:0];
        tght_pkg::REG_CLAMP: clamp   = val[7:0];
        tght_pkg::REG_EPS:   epsilon = val[19:0];
        tght_pkg::REG_DECAY: decay   = val[15:0];
        default: ;
      endcase
    endfunction

    // 1.2^(t/4) in Q8: whole degrees by repeated x1.2 in Q24, then the quarter step
    function logic [63:0] heat_of(int t);
      logic [63:0] p;
      logic [63:0] h;
      logic [63:0] frac [4];
      frac = '{64'd1048576, 64'd1097476, 64'd1148657, 64'd1202225};
      p = 64'd1 << 24;
      for (int i = 0; i < (t >> 2); i++) p = (p * 64'd6 + 64'd2) / 64'd5;
      h = (p * frac[t & 3] + (64'd1 << 35)) >> 36;
      return (h > 64'(HMAX)) ? 64'(HMAX) : h;
    endfunction

    function logic [63:0] smoothed(int r, int c);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] w;
      int d;
      num = 0; den = 0;
      for (int i = r - 1; i <= r + 1; i++)
        for (int j = c - 1; j <= c + 1; j++)
          if (i >= 0 && i < SIDE && j >= 0 && j < SIDE) begin
            d = ((i > r) ? i - r : r - i) + ((j > c) ? j - c : c - j);
            w = 64'(420 / (1 + d));
            num += heat[i * SIDE + j] * w;
            den += w;
          end
      return (2 * num + den) / (2 * den);
    endfunction

    function void note_item(logic op, logic [11:0] raw);
      int tc;
      int t;
      logic [63:0] v;
      logic [63:0] best;
      spot_t s;
      if (op == tght_pkg::OP_DECAY) begin
        last_val = ((last_val * decay + 64'h8000) >> 16) & 64'(HMAX);
        return;
      end
      tc = $signed(raw);
      if (tc < int'(low_thr)) t = 0;
      else if (tc > int'(clamp)) t = int'(clamp);
      else t = tc;
      heat[fill] = heat_of(t);
      fill++;
      if (fill < NCELLS) return;
      fill = 0;
      best = 0; s = '0;
      for (int r = 0; r < SIDE; r++)
        for (int c = 0; c < SIDE; c++) begin
          v = smoothed(r, c);
          if (v > best) begin
            best = v; s.x = 3'(c); s.y = 3'(r);
          end
        end
      if (last_ok && best < last_val + epsilon) begin
        s.x = last_x; s.y = last_y; best = last_val; s.kept = 1'b1;
      end
      last_x = s.x; last_y = s.y; last_val = best & 64'(HMAX); last_ok = 1'b1;
      s.value = best[19:0];
      s.index = {s.y, s.x};
      spots_due.push_back(s);
    endfunction

    function void check_result(logic [31:0] data, logic user);
      spot_t got;
      spot_t want;
      seen++;
      got.x = data[2:0]; got.y = data[5:3]; got.value = data[25:6];
      got.index = data[31:26]; got.kept = user;
      if (spots_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      want = spots_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // pixel_temp, zero fill
  logic        s_axis_tuser = 0;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;       // spot_x, spot_y, spot_value, spot_index
  logic        m_axis_tuser;       // kept_previous
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [tght_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hotspot_scoreboard spots = new();
  int src_idle = 0;
  int snk_stall = 0;
  int frames = 0;
  int decays = 0;

  thermal_grid_hotspot_tracker dut (.*);

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: decide tready at the falling edge, sample at the rising edge
  initial forever begin
    @(negedge clk_i);
    m_axis_tready <= ($urandom_range(99) >= snk_stall);
    @(posedge clk_i);
    if (m_axis_tvalid && m_axis_tready) spots.check_result(m_axis_tdata, m_axis_tuser);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    spots.set_reg(idx, val);
  endtask

  task automatic send_item(logic op, logic [11:0] raw);
    bit took;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= {4'd0, raw}; s_axis_tuser <= op;
    do begin
      @(posedge clk_i);
      took = s_axis_tready;
      @(negedge clk_i);
    end while (!took);
    spots.note_item(op, raw);
    if (op == tght_pkg::OP_DECAY) decays++;
  endtask

  // hold input until every result is back, then let in-flight decays settle
  task automatic drain();
    s_axis_tvalid <= 0;
    while (spots.spots_due.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic pick_config();
    int mode;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [19:0] eps;
    logic [15:0] dec;
    mode = $urandom_range(7);
    lo = 8'($urandom_range(160)); hi = 8'($urandom_range(160));
    eps = 20'($urandom_range(4096)); dec = 16'($urandom_range(65535));
    case (mode)
      0: begin lo = '0; hi = '0; end
      1: begin lo = 8'd160; hi = 8'd160; end
      2: begin lo = '0; hi = 8'd160; eps = '0; end
      3: eps = 20'hFFFFF;
      4: dec = '0;
      5: dec = 16'hFFFF;
      default: if (lo > hi && $urandom_range(1)) begin lo = hi; end
    endcase
    reg_write(tght_pkg::REG_LOW, 32'(lo));
    reg_write(tght_pkg::REG_CLAMP, 32'(hi));
    reg_write(tght_pkg::REG_EPS, 32'(eps));
    reg_write(tght_pkg::REG_DECAY, 32'(dec));
  endtask

  task automatic random_frame();
    int base;
    int spread;
    bit flat;
    logic [11:0] raw;
    base = $urandom_range(0, 170);
    spread = $urandom_range(1, 40);
    flat = ($urandom_range(9) == 0);
    for (int k = 0; k < NCELLS; k++) begin
      if ($urandom_range(99) < 4) send_item(tght_pkg::OP_DECAY, 12'($urandom_range(4095)));
      if (flat) raw = 12'(base);
      else if ($urandom_range(9) == 0) raw = 12'($urandom_range(4095));
      else raw = 12'(base - spread + $urandom_range(2 * spread));
      send_item(tght_pkg::OP_PIXEL, raw);
    end
    frames++;
    drain();
  endtask

  initial begin
    logic [11:0] edge_px [12];
    edge_px = '{12'h800, 12'h7FF, 12'd0, 12'd107, 12'd108, 12'd109,
                12'd131, 12'd132, 12'd133, 12'hFFF, 12'd160, 12'd255};
    spots.reset_state();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: decay with no hotspot yet, field extremes, thresholds at defaults
    send_item(tght_pkg::OP_DECAY, 12'hFFF);
    for (int k = 0; k < NCELLS; k++)
      send_item(tght_pkg::OP_PIXEL, (k < 12) ? edge_px[k] : 12'(110 + (k % 7)));
    frames++;
    drain();
    reg_write(tght_pkg::REG_EPS, 32'h000FFFFF);
    reg_write(tght_pkg::REG_DECAY, 32'd0);
    send_item(tght_pkg::OP_DECAY, 12'd0);
    for (int k = 0; k < NCELLS; k++) send_item(tght_pkg::OP_PIXEL, 12'd132);
    frames++;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 63; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 63; end
        default: begin src_idle = 14; snk_stall = 14; end
      endcase
      for (int f = 0; f < 6; f++) begin
        pick_config();
        random_frame();
      end
    end
    drain();
    repeat (200) @(negedge clk_i);

    $display("covered %0d frames, %0d decay items, %0d results over four idle patterns",
             frames, decays, spots.seen);
    if (spots.mismatches == 0 && spots.spots_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", spots.mismatches,
               spots.spots_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
